FILE: hw/rtl/kvs_pkg.sv
// Shared types, character codes and helpers for the framed key-value sum checker.
package kvs_pkg;

    // Width of the parsed value before it is reduced to the 32-bit result fields.
    localparam int VALUE_BITS = 32;
    localparam int ACC_W      = VALUE_BITS;
    localparam int PROD_W     = VALUE_BITS + 4;
    localparam int WIDE_W     = (VALUE_BITS > 32) ? VALUE_BITS : 32;
    localparam int OUT_W      = 32;

    // Magnitude of the most negative value: 2^(VALUE_BITS-1).
    localparam logic [PROD_W-1:0] LIM_NEG = {{(PROD_W-1){1'b0}}, 1'b1} << (VALUE_BITS - 1);

    localparam logic [7:0] RESET_START_CHAR = 8'd47;
    localparam logic [7:0] RESET_END_CHAR   = 8'd92;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_COLON = 8'd58;

    localparam logic [2:0] KEY_LEN       = 3'd5;
    localparam logic [7:0] LINE_CNT_MAX  = 8'd255;

    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHAR = 1'b0,
        CFG_END_CHAR   = 1'b1
    } cfg_idx_t;

    localparam logic KIND_LINE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Result queue depth; an item may push two records at once.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int CNT_W      = 3;

    typedef enum logic [2:0] {
        PH_LEAD,
        PH_KEY,
        PH_VLEAD,
        PH_VWS,
        PH_NUM,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic              kind;
        logic [7:0]        line_number;
        logic              is_total_line;
        logic [OUT_W-1:0]  line_value;
        logic              bad_number;
        logic              total_seen;
        logic              sum_matches;
        logic [OUT_W-1:0]  frame_sum;
        logic              last;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

    function automatic logic [7:0] total_key_char(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = 8'd84;  // T
            3'd1:    ch = 8'd79;  // O
            3'd2:    ch = 8'd84;  // T
            3'd3:    ch = 8'd65;  // A
            3'd4:    ch = 8'd76;  // L
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

FILE: hw/rtl/kvs_parser.sv
// Byte parser: frame and line state, value accumulation and record generation.
module kvs_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      accept,
    input  logic [7:0]                rx_byte,
    input  logic                      cfg_write,
    input  kvs_pkg::cfg_idx_t         cfg_index,
    input  logic [7:0]                cfg_data,
    output kvs_pkg::push_t            push
);
    import kvs_pkg::*;

    logic [7:0]        start_char_reg, start_char_next;
    logic [7:0]        end_char_reg, end_char_next;
    logic              in_frame_reg, in_frame_next;
    phase_t            phase_reg, phase_next;
    logic [2:0]        key_pos_reg, key_pos_next;
    logic              key_mismatch_reg, key_mismatch_next;
    logic              neg_reg, neg_next;
    logic [ACC_W-1:0]  accum_reg, accum_next;
    logic              vdigit_reg, vdigit_next;
    logic              vovf_reg, vovf_next;
    logic [OUT_W-1:0]  sum_reg, sum_next;
    logic [OUT_W-1:0]  total_reg, total_next;
    logic              tot_seen_reg, tot_seen_next;
    logic              err_reg, err_next;
    logic [7:0]        line_cnt_reg, line_cnt_next;

    // Line finish terms, shared by the state update and the records.
    logic              fl_has;
    logic              fl_is_total;
    logic              fl_bad;
    logic [WIDE_W-1:0] fl_wide;
    logic [WIDE_W-1:0] fl_wide_neg;
    logic [OUT_W-1:0]  fl_val;
    logic              fl_err;
    logic              fl_seen;
    logic [OUT_W-1:0]  fl_total;
    logic [OUT_W-1:0]  fl_sum;
    logic [7:0]        fl_cnt;
    logic              fl_match;

    // Digit step: accum * 10 + d, compared against the negative limit.
    logic [PROD_W-1:0] digit_prod;
    logic              digit_ovf;

    logic              is_blank;
    logic              is_vws;
    logic              is_end;
    logic              is_start;

    always_comb
    begin
        fl_has      = (phase_reg == PH_VLEAD) || (phase_reg == PH_VWS) ||
                      (phase_reg == PH_NUM) || (phase_reg == PH_DONE);
        fl_is_total = (key_pos_reg == KEY_LEN) && !key_mismatch_reg;
        fl_bad      = !vdigit_reg || vovf_reg ||
                      (!neg_reg && ({{(PROD_W-ACC_W){1'b0}}, accum_reg} >
                                    (LIM_NEG - {{(PROD_W-1){1'b0}}, 1'b1})));
        fl_wide     = {{(WIDE_W-ACC_W){1'b0}}, accum_reg};
        fl_wide_neg = {WIDE_W{1'b0}} - fl_wide;
        if (fl_bad)
            fl_val = '0;
        else if (neg_reg)
            fl_val = fl_wide_neg[OUT_W-1:0];
        else
            fl_val = fl_wide[OUT_W-1:0];
        fl_err   = err_reg | (fl_has & fl_bad);
        fl_seen  = tot_seen_reg | (fl_has & fl_is_total);
        fl_total = (fl_has && fl_is_total) ? fl_val : total_reg;
        fl_sum   = (fl_has && !fl_is_total && !fl_bad) ? (sum_reg + fl_val) : sum_reg;
        fl_cnt   = (fl_has && (line_cnt_reg != LINE_CNT_MAX)) ? (line_cnt_reg + 8'd1)
                                                              : line_cnt_reg;
        fl_match = fl_seen && !fl_err && (fl_sum == fl_total);
    end

    always_comb
    begin
        digit_prod = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0} +
                     {{(PROD_W-4){1'b0}}, rx_byte[3:0]};
        digit_ovf  = digit_prod > LIM_NEG;
        is_blank   = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB);
        is_vws     = (rx_byte == CH_CR) || (rx_byte == CH_VT) || (rx_byte == CH_FF);
        is_end     = (rx_byte == end_char_reg);
        is_start   = (rx_byte == start_char_reg);
    end

    // Next state.
    always_comb
    begin
        phase_t eff_phase;
        logic   start_value;
        logic   take_digit;

        start_char_next   = start_char_reg;
        end_char_next     = end_char_reg;
        in_frame_next     = in_frame_reg;
        phase_next        = phase_reg;
        key_pos_next      = key_pos_reg;
        key_mismatch_next = key_mismatch_reg;
        neg_next          = neg_reg;
        accum_next        = accum_reg;
        vdigit_next       = vdigit_reg;
        vovf_next         = vovf_reg;
        sum_next          = sum_reg;
        total_next        = total_reg;
        tot_seen_next     = tot_seen_reg;
        err_next          = err_reg;
        line_cnt_next     = line_cnt_reg;
        start_value       = 1'b0;
        take_digit        = 1'b0;

        if (cfg_write) begin
            case (cfg_index)
                CFG_START_CHAR: start_char_next = cfg_data;
                CFG_END_CHAR:   end_char_next   = cfg_data;
                default:        ;
            endcase
        end

        // A non-blank at line start is handled as the first key byte.
        if (phase_reg == PH_LEAD && !is_blank)
            eff_phase = PH_KEY;
        else
            eff_phase = phase_reg;

        if (accept) begin
            if (!in_frame_reg || is_end || rx_byte == CH_NL) begin
                if (!in_frame_reg) begin
                    in_frame_next = is_start;
                end else if (is_end) begin
                    in_frame_next = 1'b0;
                end else begin
                    sum_next      = fl_sum;
                    total_next    = fl_total;
                    tot_seen_next = fl_seen;
                    err_next      = fl_err;
                    line_cnt_next = fl_cnt;
                end
                // Clear the line, and the frame on open or close.
                if (in_frame_reg || is_start) begin
                    phase_next        = PH_LEAD;
                    key_pos_next      = 3'd0;
                    key_mismatch_next = 1'b0;
                    neg_next          = 1'b0;
                    accum_next        = '0;
                    vdigit_next       = 1'b0;
                    vovf_next         = 1'b0;
                end
                if ((!in_frame_reg && is_start) || (in_frame_reg && is_end)) begin
                    sum_next      = '0;
                    total_next    = '0;
                    tot_seen_next = 1'b0;
                    err_next      = 1'b0;
                    line_cnt_next = 8'd0;
                end
            end else begin
                case (eff_phase)
                    PH_LEAD: ;
                    PH_KEY:
                    begin
                        phase_next = PH_KEY;
                        if (rx_byte == CH_COLON)
                            phase_next = PH_VLEAD;
                        else if (!key_mismatch_reg && key_pos_reg < KEY_LEN &&
                                 rx_byte == total_key_char(key_pos_reg))
                            key_pos_next = key_pos_reg + 3'd1;
                        else
                            key_mismatch_next = 1'b1;
                    end
                    PH_VLEAD:
                    begin
                        if (is_vws)
                            phase_next = PH_VWS;
                        else if (!is_blank)
                            start_value = 1'b1;
                    end
                    PH_VWS:
                    begin
                        if (rx_byte == CH_SPACE)
                            phase_next = PH_DONE;
                        else if (!(is_vws || rx_byte == CH_TAB))
                            start_value = 1'b1;
                    end
                    PH_NUM:
                    begin
                        if (is_digit(rx_byte))
                            take_digit = 1'b1;
                        else
                            phase_next = PH_DONE;
                    end
                    PH_DONE: ;
                    default: ;
                endcase

                if (start_value) begin
                    phase_next = PH_NUM;
                    if (rx_byte == CH_MINUS)
                        neg_next = 1'b1;
                    else if (is_digit(rx_byte))
                        take_digit = 1'b1;
                    else if (rx_byte != CH_PLUS)
                        phase_next = PH_DONE;
                end

                // Once overflowed, further digits leave the accumulator alone.
                if (take_digit) begin
                    vdigit_next = 1'b1;
                    if (!vovf_reg) begin
                        if (digit_ovf)
                            vovf_next = 1'b1;
                        else
                            accum_next = digit_prod[ACC_W-1:0];
                    end
                end
            end
        end
    end

    // Records caused by the accepted item.
    always_comb
    begin
        rec_t line_rec;
        rec_t sum_rec;

        line_rec.kind          = KIND_LINE;
        line_rec.line_number   = line_cnt_reg;
        line_rec.is_total_line = fl_is_total;
        line_rec.line_value    = fl_val;
        line_rec.bad_number    = fl_bad;
        line_rec.total_seen    = 1'b0;
        line_rec.sum_matches   = 1'b0;
        line_rec.frame_sum     = '0;
        line_rec.last          = !is_end;

        sum_rec.kind          = KIND_SUMMARY;
        sum_rec.line_number   = fl_cnt;
        sum_rec.is_total_line = 1'b0;
        sum_rec.line_value    = fl_total;
        sum_rec.bad_number    = fl_err;
        sum_rec.total_seen    = fl_seen;
        sum_rec.sum_matches   = fl_match;
        sum_rec.frame_sum     = fl_sum;
        sum_rec.last          = 1'b1;

        push.count = 2'd0;
        push.rec0  = line_rec;
        push.rec1  = sum_rec;
        if (accept && in_frame_reg) begin
            if (is_end) begin
                if (fl_has) begin
                    push.count = 2'd2;
                end else begin
                    push.count = 2'd1;
                    push.rec0  = sum_rec;
                end
            end else if (rx_byte == CH_NL && fl_has) begin
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            start_char_reg   <= RESET_START_CHAR;
            end_char_reg     <= RESET_END_CHAR;
            in_frame_reg     <= 1'b0;
            phase_reg        <= PH_LEAD;
            key_pos_reg      <= 3'd0;
            key_mismatch_reg <= 1'b0;
            neg_reg          <= 1'b0;
            accum_reg        <= '0;
            vdigit_reg       <= 1'b0;
            vovf_reg         <= 1'b0;
            sum_reg          <= '0;
            total_reg        <= '0;
            tot_seen_reg     <= 1'b0;
            err_reg          <= 1'b0;
            line_cnt_reg     <= 8'd0;
        end else begin
            start_char_reg   <= start_char_next;
            end_char_reg     <= end_char_next;
            in_frame_reg     <= in_frame_next;
            phase_reg        <= phase_next;
            key_pos_reg      <= key_pos_next;
            key_mismatch_reg <= key_mismatch_next;
            neg_reg          <= neg_next;
            accum_reg        <= accum_next;
            vdigit_reg       <= vdigit_next;
            vovf_reg         <= vovf_next;
            sum_reg          <= sum_next;
            total_reg        <= total_next;
            tot_seen_reg     <= tot_seen_next;
            err_reg          <= err_next;
            line_cnt_reg     <= line_cnt_next;
        end
    end

endmodule

FILE: hw/rtl/kvs_rec_fifo.sv
// Result record queue taking up to two records per cycle and giving one.
module kvs_rec_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  kvs_pkg::push_t  push,
    input  logic            pop,
    output kvs_pkg::rec_t   head,
    output logic            not_empty,
    output logic            room_two
);
    import kvs_pkg::*;

    rec_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PTR_W-1:0] wr_ptr_plus1;

    always_comb
    begin
        wr_ptr_plus1 = wr_ptr_reg + {{(PTR_W-1){1'b0}}, 1'b1};
        wr_ptr_next  = wr_ptr_reg + push.count[PTR_W-1:0];
        rd_ptr_next  = rd_ptr_reg + {{(PTR_W-1){1'b0}}, pop};
        count_next   = count_reg + {{(CNT_W-2){1'b0}}, push.count}
                       - {{(CNT_W-1){1'b0}}, pop};
        head         = mem[rd_ptr_reg];
        not_empty    = (count_reg != '0);
        room_two     = (count_reg <= CNT_W'(FIFO_DEPTH - 2));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.rec0;
        if (push.count == 2'd2)
            mem[wr_ptr_plus1] <= push.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/framed_keyvalue_sum_checker.sv
// Top level of the framed key-value sum checker: ports, handshakes and result queue.
//
// Accepts one received byte per clock cycle while input ready is high. Each byte
// updates the parser state in the cycle it is accepted; any records it causes enter
// a four-entry result queue, which registers them before they reach the output. A
// newline yields one line record if its line reached a colon, and a frame end yields
// any pending line record followed by the frame summary, both in the same cycle.
// Input ready stays high while the queue has two free entries, so with the output
// side taking one record per cycle the input runs at one byte per cycle without
// pause. Configuration writes are always ready and take effect on the next cycle.
module framed_keyvalue_sum_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        rx_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              result_kind,
    output logic [7:0]                        line_number,
    output logic                              is_total_line,
    output logic signed [kvs_pkg::OUT_W-1:0]  line_value,
    output logic                              bad_number,
    output logic                              total_seen,
    output logic                              sum_matches,
    output logic signed [kvs_pkg::OUT_W-1:0]  frame_sum,
    output logic                              last,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [kvs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [7:0]                        cfg_data
);
    import kvs_pkg::*;

    push_t push;
    rec_t  head;
    logic  accept;
    logic  room_two;
    logic  not_empty;

    assign cfg_ready = 1'b1;
    assign in_ready  = room_two;
    assign accept    = in_valid && room_two;
    assign out_valid = not_empty;

    kvs_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_idx_t'(cfg_index)),
        .cfg_data  (cfg_data),
        .push      (push)
    );

    kvs_rec_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (not_empty && out_ready),
        .head      (head),
        .not_empty (not_empty),
        .room_two  (room_two)
    );

    assign result_kind   = head.kind;
    assign line_number   = head.line_number;
    assign is_total_line = head.is_total_line;
    assign line_value    = head.line_value;
    assign bad_number    = head.bad_number;
    assign total_seen    = head.total_seen;
    assign sum_matches   = head.sum_matches;
    assign frame_sum     = head.frame_sum;
    assign last          = head.last;

endmodule

FILE: sim/tb_framed_keyvalue_sum_checker.sv
// Self-checking testbench for the framed key-value sum checker.
module tb_framed_keyvalue_sum_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import kvs_pkg::*;

    localparam logic [7:0]  CH_TAB        = 8'd9;
    localparam logic [7:0]  CH_NL         = 8'd10;
    localparam logic [7:0]  CH_VT         = 8'd11;
    localparam logic [7:0]  CH_FF         = 8'd12;
    localparam logic [7:0]  CH_CR         = 8'd13;
    localparam logic [7:0]  CH_SPACE      = 8'd32;
    localparam logic [7:0]  CH_HASH       = 8'd35;
    localparam logic [7:0]  CH_PLUS       = 8'd43;
    localparam logic [7:0]  CH_MINUS      = 8'd45;
    localparam logic [7:0]  CH_SLASH      = 8'd47;
    localparam logic [7:0]  CH_ZERO       = 8'd48;
    localparam logic [7:0]  CH_NINE       = 8'd57;
    localparam logic [7:0]  CH_COLON      = 8'd58;
    localparam logic [7:0]  CH_BACKSLASH  = 8'd92;
    localparam logic [7:0]  CH_LOWER_A    = 8'd97;
    localparam logic [39:0] TOTAL_WORD    = "TOTAL";
    localparam int          KEY_CHARS     = 5;
    localparam logic [63:0] NEG_LIMIT     = 64'd1 << (VALUE_BITS - 1);
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          PHASE_BYTES   = 110;

    typedef struct packed {
        logic        kind;
        logic [7:0]  line_number;
        logic        is_total;
        logic [31:0] line_value;
        logic        bad;
        logic        total_seen;
        logic        sum_ok;
        logic [31:0] frame_sum;
        logic        last;
    } kv_record_t;

    // Tracks the parser state of the block and holds the records it still owes.
    class kv_frame_scoreboard;
        logic [7:0]  start_char;
        logic [7:0]  end_char;
        logic        in_frame;
        phase_t      state_ph;
        int unsigned key_pos;
        logic        key_bad;
        logic        negative;
        logic        seen_digit;
        logic        overflow;
        logic [63:0] magnitude;
        logic [31:0] good_sum;
        logic [31:0] total_value;
        logic        total_flag;
        logic        error_flag;
        logic [7:0]  line_count;
        kv_record_t  pending_records[$];
        int          failures;
        int          line_records;
        int          frame_summaries;
        int          balanced_frames;

        function new();
            start_char = CH_SLASH;
            end_char = CH_BACKSLASH;
            in_frame = 1'b0;
            failures = 0;
            line_records = 0;
            frame_summaries = 0;
            balanced_frames = 0;
            clear_frame();
        endfunction

        function void set_char(cfg_idx_t idx, logic [7:0] ch);
            if (idx == CFG_START_CHAR)
                start_char = ch;
            else
                end_char = ch;
        endfunction

        function void clear_line();
            state_ph = PH_LEAD;
            key_pos = 0;
            key_bad = 1'b0;
            negative = 1'b0;
            seen_digit = 1'b0;
            overflow = 1'b0;
            magnitude = '0;
        endfunction

        function void clear_frame();
            clear_line();
            good_sum = '0;
            total_value = '0;
            total_flag = 1'b0;
            error_flag = 1'b0;
            line_count = '0;
        endfunction

        function void add_digit(logic [7:0] c);
            logic [63:0] d;
            d = {56'd0, c - CH_ZERO};
            seen_digit = 1'b1;
            if (!overflow)
            begin
                if (magnitude > (NEG_LIMIT - d) / 10)
                    overflow = 1'b1;
                else
                    magnitude = magnitude * 10 + d;
            end
        endfunction

        function void start_value(logic [7:0] c);
            state_ph = PH_NUM;
            if (c == CH_MINUS)
                negative = 1'b1;
            else if (c >= CH_ZERO && c <= CH_NINE)
                add_digit(c);
            else if (c != CH_PLUS)
                state_ph = PH_DONE;
        endfunction

        function void parse_byte(logic [7:0] c);
            if (state_ph == PH_LEAD && c != CH_SPACE && c != CH_TAB)
                state_ph = PH_KEY;
            case (state_ph)
                PH_KEY:
                begin
                    if (c == CH_COLON)
                        state_ph = PH_VLEAD;
                    else if (!key_bad && key_pos < KEY_CHARS &&
                             c == TOTAL_WORD[8 * (KEY_CHARS - 1 - key_pos) +: 8])
                        key_pos++;
                    else
                        key_bad = 1'b1;
                end
                PH_VLEAD:
                begin
                    if (c == CH_CR || c == CH_VT || c == CH_FF)
                        state_ph = PH_VWS;
                    else if (c != CH_SPACE && c != CH_TAB)
                        start_value(c);
                end
                PH_VWS:
                begin
                    // A space after the vertical blanks ends the value with no digits.
                    if (c == CH_SPACE)
                        state_ph = PH_DONE;
                    else if (c != CH_TAB && c != CH_CR && c != CH_VT && c != CH_FF)
                        start_value(c);
                end
                PH_NUM:
                begin
                    if (c >= CH_ZERO && c <= CH_NINE)
                        add_digit(c);
                    else
                        state_ph = PH_DONE;
                end
                default:
                    ;
            endcase
        endfunction

        // Closes the current line; only a line that reached its colon yields a record.
        function void close_line(logic fin);
            logic        is_total;
            logic        bad;
            logic [63:0] wide_value;
            kv_record_t  rec;
            if (state_ph == PH_LEAD || state_ph == PH_KEY)
            begin
                clear_line();
                return;
            end
            is_total = (key_pos == KEY_CHARS) && !key_bad;
            bad = !seen_digit || overflow || (!negative && magnitude > NEG_LIMIT - 1);
            wide_value = negative ? (64'd0 - magnitude) : magnitude;
            rec = '0;
            rec.kind = KIND_LINE;
            rec.line_number = line_count;
            rec.is_total = is_total;
            rec.line_value = bad ? 32'd0 : wide_value[31:0];
            rec.bad = bad;
            rec.last = fin;
            if (bad)
                error_flag = 1'b1;
            if (is_total)
            begin
                total_flag = 1'b1;
                total_value = rec.line_value;
            end
            else if (!bad)
                good_sum = good_sum + rec.line_value;
            if (line_count != 8'd255)
                line_count++;
            pending_records.insert(pending_records.size(), rec);
            line_records++;
            clear_line();
        endfunction

        function void note_byte(logic [7:0] c);
            kv_record_t summary;
            if (!in_frame)
            begin
                // Anything but the start character is dropped outside a frame.
                if (c == start_char)
                begin
                    in_frame = 1'b1;
                    clear_frame();
                end
            end
            else if (c == end_char)
            begin
                close_line(1'b0);
                summary = '0;
                summary.kind = KIND_SUMMARY;
                summary.line_number = line_count;
                summary.line_value = total_value;
                summary.bad = error_flag;
                summary.total_seen = total_flag;
                summary.sum_ok = total_flag && !error_flag && good_sum == total_value;
                summary.frame_sum = good_sum;
                summary.last = 1'b1;
                pending_records.insert(pending_records.size(), summary);
                frame_summaries++;
                if (summary.sum_ok)
                    balanced_frames++;
                in_frame = 1'b0;
                clear_frame();
            end
            else if (c == CH_NL)
                close_line(1'b1);
            else
                parse_byte(c);
        endfunction

        function string describe(kv_record_t r);
            return $sformatf({"kind=%0d line=%0d total=%0d value=%0d bad=%0d ",
                              "seen=%0d ok=%0d sum=%0d last=%0d"},
                             r.kind, r.line_number, r.is_total, $signed(r.line_value), r.bad,
                             r.total_seen, r.sum_ok, $signed(r.frame_sum), r.last);
        endfunction

        function void check_record(kv_record_t got);
            kv_record_t want;
            if (pending_records.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: unexpected record %s", describe(got));
                return;
            end
            want = pending_records.pop_front();
            if (got !== want)
            begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: record mismatch\n  expected %s\n  actual   %s",
                             describe(want), describe(got));
            end
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [7:0]              rx_byte = 8'd0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic                    result_kind;
    logic [7:0]              line_number;
    logic                    is_total_line;
    logic signed [OUT_W-1:0] line_value;
    logic                    bad_number;
    logic                    total_seen;
    logic                    sum_matches;
    logic signed [OUT_W-1:0] frame_sum;
    logic                    last;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    cfg_idx_t                cfg_index = CFG_START_CHAR;
    logic [7:0]              cfg_data = 8'd0;

    kv_frame_scoreboard sb;
    logic [7:0]         stream_q[$];
    logic [7:0]         start_ch = CH_SLASH;
    logic [7:0]         end_ch = CH_BACKSLASH;
    int                 burst_left = 0;
    int                 gap_left = 0;
    int                 bytes_sent = 0;
    int                 settings_used = 1;
    int                 idle_cycles = 0;
    int                 stall_left = 0;
    int                 stall_mode = 0;
    logic [31:0]        cycle_count = '0;

    framed_keyvalue_sum_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_kind   (result_kind),
        .line_number   (line_number),
        .is_total_line (is_total_line),
        .line_value    (line_value),
        .bad_number    (bad_number),
        .total_seen    (total_seen),
        .sum_matches   (sum_matches),
        .frame_sum     (frame_sum),
        .last          (last),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Result side: check every accepted record and stall in changing patterns.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && out_valid && out_ready)
            sb.check_record('{result_kind, line_number, is_total_line, line_value, bad_number,
                              total_seen, sum_matches, frame_sum, last});
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(20, 80);
        end
        else
            stall_left <= stall_left - 1;
        case (stall_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= (cycle_count[1:0] == 2'd0);
            default: out_ready <= (cycle_count[4:0] > 5'd24);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", idle_cycles);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic void push_ch(logic [7:0] c);
        stream_q.insert(stream_q.size(), c);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.insert(stream_q.size(), s[i]);
    endfunction

    function automatic void push_int(int v);
        push_text($sformatf("%0d", v));
    endfunction

    // Values at and past the 32-bit edges, and values with no digits at all.
    function automatic void push_edge_value();
        case ($urandom_range(0, 11))
            0:  push_text("2147483648");
            1:  push_text("-2147483649");
            2:  push_text("99999999999");
            3:  ;
            4:  push_text("-");
            5:  push_text("+x");
            6:
            begin
                push_ch(CH_CR);
                push_text(" 7");
            end
            7:  push_text("-2147483648");
            8:  push_text("2147483647");
            9:  push_text("+0");
            10:
            begin
                push_ch(CH_VT);
                push_ch(CH_FF);
                push_text("-12");
            end
            default: push_text("-0");
        endcase
    endfunction

    // One frame of lines; with aim_match the TOTAL line carries the wrapped sum.
    function automatic void add_frame(bit aim_match);
        int          n_lines;
        int          v;
        logic [31:0] running;
        n_lines = $urandom_range(0, 5);
        running = '0;
        push_ch(start_ch);
        for (int i = 0; i < n_lines; i++)
        begin
            repeat ($urandom_range(0, 2))
                push_ch($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            case ($urandom_range(0, 9))
                0: ;
                1: push_text("TOTAL ");
                2: push_text("TOTA");
                3: push_text("TOTALX");
                4: push_text(aim_match ? "n" : "TOTAL");
                default:
                    repeat ($urandom_range(1, 4))
                        push_ch(CH_LOWER_A + 8'($urandom_range(0, 25)));
            endcase
            if (!aim_match && $urandom_range(0, 9) == 0)
            begin
                push_text(" no colon");
                push_ch(CH_NL);
                continue;
            end
            push_ch(CH_COLON);
            if (aim_match || $urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 5))
                    0: push_ch(CH_SPACE);
                    1: push_ch(CH_TAB);
                    2: push_ch(CH_CR);
                    3:
                    begin
                        push_text(" \t");
                        push_ch(CH_FF);
                    end
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0)
                    v = int'($urandom);
                else
                    v = int'($urandom_range(0, 2000000)) - 1000000;
                if (v >= 0 && $urandom_range(0, 3) == 0)
                    push_ch(CH_PLUS);
                push_int(v);
                running = running + v;
            end
            else
                push_edge_value();
            if ($urandom_range(0, 4) == 0)
                push_text(" end;9");
            push_ch(CH_NL);
        end
        if (aim_match)
        begin
            push_text("TOTAL:");
            push_int(int'(running));
            push_ch(CH_NL);
        end
        else
        begin
            repeat ($urandom_range(0, 2))
            begin
                push_text("TOTAL:");
                if ($urandom_range(0, 2) == 0)
                    push_edge_value();
                else
                    push_int(int'($urandom));
                push_ch(CH_NL);
            end
        end
        // An unterminated line is flushed by the end character.
        if ($urandom_range(0, 3) == 0)
        begin
            push_text("tail:");
            push_int(int'($urandom_range(0, 999)));
        end
        push_ch(end_ch);
    endfunction

    function automatic void add_random_part(int budget);
        int target;
        target = stream_q.size() + budget;
        while (stream_q.size() < target)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_frame(1'b1);
                4, 5, 6, 7: add_frame(1'b0);
                8:
                begin
                    push_ch(start_ch);
                    repeat ($urandom_range(3, 12))
                        push_ch(8'($urandom_range(0, 255)));
                    push_ch(end_ch);
                end
                default:
                begin
                    if ($urandom_range(0, 1))
                        push_ch(end_ch);
                    repeat ($urandom_range(1, 4))
                        push_ch(8'($urandom_range(0, 255)));
                end
            endcase
        end
    endfunction

    // More than 255 key-value lines, so the line number saturates.
    function automatic void add_long_frame();
        push_ch(start_ch);
        for (int i = 0; i < 280; i++)
        begin
            push_ch(CH_COLON);
            if ($urandom_range(0, 1))
                push_ch(CH_ZERO + 8'($urandom_range(0, 9)));
            push_ch(CH_NL);
        end
        push_ch(end_ch);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_left) @(posedge clk);
            gap_left = 0;
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_byte(b);
        bytes_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
    endtask

    task automatic send_stream();
        while (stream_q.size() > 0)
            send_byte(stream_q.pop_front());
    endtask

    // Holds the input back until every owed record is out and the parser has settled.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_records.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_chars(input logic [7:0] s, input logic [7:0] e);
        bit       end_first;
        cfg_idx_t idx;
        end_first = 1'($urandom_range(0, 1));
        for (int k = 0; k < 2; k++)
        begin
            idx = ((k == 1) != end_first) ? CFG_END_CHAR : CFG_START_CHAR;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data <= (idx == CFG_START_CHAR) ? s : e;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            sb.set_char(idx, (idx == CFG_START_CHAR) ? s : e);
        end
        cfg_valid <= 1'b0;
        start_ch = s;
        end_ch = e;
        settings_used++;
    endtask

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Byte extremes and a stray end outside a frame, then one frame with a TOTAL
        // line, a plain line, an empty line and a pending line flushed by the end.
        push_ch(8'h00);
        push_ch(8'hFF);
        push_ch(CH_BACKSLASH);
        push_text("/ \tTOTAL:-7\nab:-7\n\nq:9");
        push_ch(CH_BACKSLASH);
        send_stream();
        wait_idle();

        add_long_frame();
        add_random_part(PHASE_BYTES);
        send_stream();
        wait_idle();

        for (int p = 1; p <= 6; p++)
        begin
            case (p)
                1: write_chars(8'h00, 8'hFF);
                2: write_chars(8'hFF, 8'h00);
                3: write_chars(CH_SLASH, CH_NL);
                4: write_chars(CH_HASH, CH_HASH);
                5: write_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: write_chars(CH_SLASH, CH_BACKSLASH);
            endcase
            add_random_part(PHASE_BYTES);
            send_stream();
            wait_idle();
        end

        repeat (8) @(posedge clk);
        $display("Sent %0d bytes under %0d start/end character settings.",
                 bytes_sent, settings_used);
        $display("Predicted %0d line records and %0d frame summaries, %0d with a matching total.",
                 sb.line_records, sb.frame_summaries, sb.balanced_frames);
        if (sb.failures == 0 && sb.pending_records.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d failures, %0d records never arrived",
                     sb.failures, sb.pending_records.size());
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: framed_keyvalue_sum_checker.f
hw/rtl/kvs_pkg.sv
hw/rtl/kvs_parser.sv
hw/rtl/kvs_rec_fifo.sv
hw/rtl/framed_keyvalue_sum_checker.sv
sim/tb_framed_keyvalue_sum_checker.sv
